>>> hdl/process_slot_queue_top_macros.svh
// Assertion macros for the process slot queue.
// Taken in by the files that carry concurrent checks; no other dependencies.
`ifndef PROCESS_SLOT_QUEUE_TOP_MACROS_SVH
`define PROCESS_SLOT_QUEUE_TOP_MACROS_SVH

// Check that a condition always holds outside reset.
`define PSQ_ASSERT_ALW(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
   else $error("psq: invariant violated");

// Check a same-cycle implication.
`define PSQ_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
   else $error("psq: implication violated");

// Check a next-cycle implication.
`define PSQ_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
   else $error("psq: next-cycle implication violated");

`endif

>>> hdl/psq_pkg.sv
// Shared types and codes for the process slot queue.
// Used by the controller, the datapath and the top level; no dependencies.
package psq_pkg;

   localparam int OP_W   = 2;
   localparam int ID_W   = 16;
   localparam int TIME_W = 16;
   localparam int ST_W   = 2;
   localparam int FILL_W = 5;

   // Operation codes
   localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
   localparam logic [OP_W-1:0] OP_POP    = 2'd1;
   localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;
   localparam logic [OP_W-1:0] OP_CHECK  = 2'd3;

   // Status codes
   localparam logic [ST_W-1:0] ST_OK       = 2'd0;
   localparam logic [ST_W-1:0] ST_EMPTY    = 2'd1;
   localparam logic [ST_W-1:0] ST_FULL     = 2'd2;
   localparam logic [ST_W-1:0] ST_NOTFOUND = 2'd3;

   typedef struct packed {
      logic [ID_W-1:0]   id;
      logic [TIME_W-1:0] start;
      logic [TIME_W-1:0] len;
   } entry_type;

   // Commands from controller to datapath
   typedef struct packed {
      logic            latch;
      logic            rd_first;
      logic            rd_next;
      logic            wr_tail;
      logic            wr_shift;
      logic            count_dec;
      logic            set_status;
      logic [ST_W-1:0] status_code;
      logic            set_free;
      logic            clr_free;
      logic            capture_pop;
      logic            load_rsp;
   } cmd_type;

   // Status from datapath to controller
   typedef struct packed {
      logic [OP_W-1:0] op;
      logic            empty;
      logic            full;
      logic            last;
      logic            id_match;
      logic            overlap;
      logic            rsp_free;
   } sts_type;

endpackage

>>> hdl/psq_ctrl.sv
// Controller state machine for the process slot queue.
// Depends on psq_pkg and process_slot_queue_top_macros.svh.
`include "process_slot_queue_top_macros.svh"

module psq_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  psq_pkg::sts_type  sts,
   output psq_pkg::cmd_type  cmd
);
   import psq_pkg::*;

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_EXEC   = 3'd1;
   localparam logic [2:0] S_SCAN   = 3'd2;
   localparam logic [2:0] S_SHIFT  = 3'd3;
   localparam logic [2:0] S_FINISH = 3'd4;

   logic [2:0] state_ff, state_in;
   logic       req_fire;
   logic       match;

   assign req_stall = (state_ff != S_IDLE);
   assign req_fire  = req_valid && !req_stall;
   // pop always takes the head; remove needs an id hit
   assign match     = (sts.op == OP_POP) || sts.id_match;

   // Decode state and status into datapath commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               cmd.latch = 1'b1;
               state_in  = S_EXEC;
            end
         end
         S_EXEC: begin
            state_in = S_FINISH;
            case (sts.op)
               OP_INSERT: begin
                  if (sts.full) begin
                     cmd.set_status  = 1'b1;
                     cmd.status_code = ST_FULL;
                  end else begin
                     cmd.wr_tail = 1'b1;
                  end
               end
               OP_POP, OP_REMOVE: begin
                  if (sts.empty) begin
                     cmd.set_status  = 1'b1;
                     cmd.status_code = ST_EMPTY;
                  end else begin
                     cmd.rd_first = 1'b1;
                     state_in     = S_SCAN;
                  end
               end
               OP_CHECK: begin
                  cmd.set_free = 1'b1;
                  if (!sts.empty) begin
                     cmd.rd_first = 1'b1;
                     state_in     = S_SCAN;
                  end
               end
               default: ;
            endcase
         end
         S_SCAN: begin
            if (sts.op == OP_CHECK) begin
               // stop at the first overlap
               if (sts.overlap) begin
                  cmd.clr_free = 1'b1;
                  state_in     = S_FINISH;
               end else if (sts.last) begin
                  state_in = S_FINISH;
               end else begin
                  cmd.rd_next = 1'b1;
               end
            end else if (match) begin
               cmd.capture_pop = (sts.op == OP_POP);
               if (sts.last) begin
                  cmd.count_dec = 1'b1;
                  state_in      = S_FINISH;
               end else begin
                  cmd.rd_next = 1'b1;
                  state_in    = S_SHIFT;
               end
            end else if (sts.last) begin
               cmd.set_status  = 1'b1;
               cmd.status_code = ST_NOTFOUND;
               state_in        = S_FINISH;
            end else begin
               cmd.rd_next = 1'b1;
            end
         end
         S_SHIFT: begin
            // close the gap one entry per cycle
            cmd.wr_shift = 1'b1;
            if (sts.last) begin
               cmd.count_dec = 1'b1;
               state_in      = S_FINISH;
            end else begin
               cmd.rd_next = 1'b1;
            end
         end
         S_FINISH: begin
            if (sts.rsp_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Advance state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   `PSQ_ASSERT_NXT(a_accept_exec, clock, reset, req_fire, state_ff == S_EXEC)
   `PSQ_ASSERT_IMP(a_load_free, clock, reset, cmd.load_rsp, sts.rsp_free)

endmodule

>>> hdl/psq_datapath.sv
// Datapath of the process slot queue: entry memory, walk index, fill count,
// result registers and the output register. Depends on psq_pkg and the macros header.
`include "process_slot_queue_top_macros.svh"

module psq_datapath #(
   parameter int DEPTH = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  psq_pkg::cmd_type             cmd,
   output psq_pkg::sts_type             sts,
   input  logic [psq_pkg::OP_W-1:0]     req_operation,
   input  logic [psq_pkg::ID_W-1:0]     req_proc_id,
   input  logic [psq_pkg::TIME_W-1:0]   req_start_time,
   input  logic [psq_pkg::TIME_W-1:0]   req_run_length,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [psq_pkg::ST_W-1:0]     rsp_status,
   output logic                         rsp_slot_free,
   output logic [psq_pkg::ID_W-1:0]     rsp_out_id,
   output logic [psq_pkg::TIME_W-1:0]   rsp_out_start,
   output logic [psq_pkg::TIME_W-1:0]   rsp_out_length,
   output logic [psq_pkg::FILL_W-1:0]   rsp_fill_count
);
   import psq_pkg::*;

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   // Latched request
   logic [OP_W-1:0]   op_ff;
   entry_type         req_ff;

   // Entry memory and its registered read port
   entry_type         store_ff [DEPTH];
   entry_type         rd_data_ff;
   logic              rd_en, wr_en;
   logic [AW-1:0]     rd_addr, wr_addr;
   entry_type         wr_data;

   logic [AW-1:0]     idx_ff;
   logic [CW-1:0]     count_ff;

   // Result of the item under work
   logic [ST_W-1:0]   status_ff;
   logic              free_ff;
   entry_type         pop_ff;

   // Output register
   logic              rsp_valid_ff;
   logic [ST_W-1:0]   rsp_status_ff;
   logic              rsp_free_ff;
   entry_type         rsp_entry_ff;
   logic [FILL_W-1:0] rsp_fill_ff;

   logic [TIME_W:0]   stored_end, req_end;

   // Latch the accepted item
   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         op_ff        <= req_operation;
         req_ff.id    <= req_proc_id;
         req_ff.start <= req_start_time;
         req_ff.len   <= req_run_length;
      end
   end

   // Select memory addresses
   assign rd_en   = cmd.rd_first || cmd.rd_next;
   assign rd_addr = cmd.rd_next ? (idx_ff + AW'(1)) : '0;
   assign wr_en   = cmd.wr_tail || cmd.wr_shift;
   assign wr_addr = cmd.wr_shift ? (idx_ff - AW'(1)) : count_ff[AW-1:0];
   assign wr_data = cmd.wr_shift ? rd_data_ff : req_ff;

   // Entry memory: one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= store_ff[rd_addr];
      end
   end

   // Track walk index and fill count
   always_ff @(posedge clock) begin
      if (rd_en) begin
         idx_ff <= rd_addr;
      end
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.wr_tail) begin
         count_ff <= count_ff + CW'(1);
      end else if (cmd.count_dec) begin
         count_ff <= count_ff - CW'(1);
      end
   end

   // Hold result fields of the current item
   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         status_ff <= ST_OK;
         free_ff   <= 1'b0;
         pop_ff    <= '0;
      end else begin
         if (cmd.set_status) begin
            status_ff <= cmd.status_code;
         end
         if (cmd.set_free) begin
            free_ff <= 1'b1;
         end else if (cmd.clr_free) begin
            free_ff <= 1'b0;
         end
         if (cmd.capture_pop) begin
            pop_ff <= rd_data_ff;
         end
      end
   end

   // Output register: load when free, drop when taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_status_ff <= status_ff;
         rsp_free_ff   <= free_ff;
         rsp_entry_ff  <= pop_ff;
         rsp_fill_ff   <= FILL_W'(count_ff);
      end
   end

   // Inclusive-boundary overlap against the entry just read
   assign stored_end = {1'b0, rd_data_ff.start} + {1'b0, rd_data_ff.len};
   assign req_end    = {1'b0, req_ff.start} + {1'b0, req_ff.len};

   always_comb begin
      sts          = '0;
      sts.op       = op_ff;
      sts.empty    = (count_ff == '0);
      sts.full     = (count_ff == CW'(DEPTH));
      sts.last     = ((CW'(idx_ff) + CW'(1)) == count_ff);
      sts.id_match = (rd_data_ff.id == req_ff.id);
      sts.overlap  = ((req_ff.start >= rd_data_ff.start)
                      && ({1'b0, req_ff.start} <= stored_end))
                     || ((req_ff.start <= rd_data_ff.start)
                      && (req_end >= {1'b0, rd_data_ff.start}));
      sts.rsp_free = !rsp_valid_ff || !rsp_stall;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_slot_free  = rsp_free_ff;
   assign rsp_out_id     = rsp_entry_ff.id;
   assign rsp_out_start  = rsp_entry_ff.start;
   assign rsp_out_length = rsp_entry_ff.len;
   assign rsp_fill_count = rsp_fill_ff;

   `PSQ_ASSERT_ALW(a_count_bound, clock, reset, count_ff <= CW'(DEPTH))
   `PSQ_ASSERT_NXT(a_tail_inc, clock, reset, cmd.wr_tail,
      count_ff == $past(count_ff) + CW'(1))

endmodule

>>> hdl/process_slot_queue_top.sv
// Process slot queue: ordered queue with insert, pop, remove by id and an
// interval check. Insert, and any operation on an empty queue, runs through the
// execute and finish states only; pop, remove and check walk the stored
// entries through the single read port of the entry memory, one entry per
// cycle, so they take longer the more entries are stored. One item is worked on at a time;
// the next item is accepted once the result is in the output register, even
// while that result still waits to be taken. No clearing pass follows reset.
// Depends on psq_pkg, psq_ctrl and psq_datapath.
module process_slot_queue_top #(
   parameter int DEPTH = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [psq_pkg::OP_W-1:0]     req_operation,
   input  logic [psq_pkg::ID_W-1:0]     req_proc_id,
   input  logic [psq_pkg::TIME_W-1:0]   req_start_time,
   input  logic [psq_pkg::TIME_W-1:0]   req_run_length,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [psq_pkg::ST_W-1:0]     rsp_status,
   output logic                         rsp_slot_free,
   output logic [psq_pkg::ID_W-1:0]     rsp_out_id,
   output logic [psq_pkg::TIME_W-1:0]   rsp_out_start,
   output logic [psq_pkg::TIME_W-1:0]   rsp_out_length,
   output logic [psq_pkg::FILL_W-1:0]   rsp_fill_count
);
   import psq_pkg::*;

   cmd_type cmd;
   sts_type sts;

   // Sequence each item
   psq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   // Store entries and form results
   psq_datapath #(
      .DEPTH (DEPTH)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .sts            (sts),
      .req_operation  (req_operation),
      .req_proc_id    (req_proc_id),
      .req_start_time (req_start_time),
      .req_run_length (req_run_length),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_status     (rsp_status),
      .rsp_slot_free  (rsp_slot_free),
      .rsp_out_id     (rsp_out_id),
      .rsp_out_start  (rsp_out_start),
      .rsp_out_length (rsp_out_length),
      .rsp_fill_count (rsp_fill_count)
   );

endmodule

>>> sim/tb.sv
`timescale 1ns / 1ps
// Self-checking bench for process_slot_queue_top: sends insert, pop, remove and
// interval-check commands and compares every reply with a behavioural queue model.
// Depends on psq_pkg and the process slot queue RTL.
module tb;
   import psq_pkg::*;

   localparam int DEPTH = 16;
   localparam int CYCLE_LIMIT = 400000;

   typedef struct packed {
      logic [ST_W-1:0]   status;
      logic              slot_free;
      logic [ID_W-1:0]   id;
      logic [TIME_W-1:0] start;
      logic [TIME_W-1:0] len;
      logic [FILL_W-1:0] fill;
   } reply_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic [OP_W-1:0]     req_operation = '0;
   logic [ID_W-1:0]     req_proc_id = '0;
   logic [TIME_W-1:0]   req_start_time = '0;
   logic [TIME_W-1:0]   req_run_length = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [ST_W-1:0]     rsp_status;
   logic                rsp_slot_free;
   logic [ID_W-1:0]     rsp_out_id;
   logic [TIME_W-1:0]   rsp_out_start;
   logic [TIME_W-1:0]   rsp_out_length;
   logic [FILL_W-1:0]   rsp_fill_count;

   // Queue model and the replies still owed by the block
   entry_type   model_slots [DEPTH];
   int unsigned model_fill = 0;
   reply_type   replies_due [$];

   int errors = 0;
   int cycles = 0;
   int stall_left = 0;
   bit sender_steady = 1'b0;
   bit receiver_steady = 1'b0;

   process_slot_queue_top #(
      .DEPTH(DEPTH)
   ) DUT (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_operation  (req_operation),
      .req_proc_id    (req_proc_id),
      .req_start_time (req_start_time),
      .req_run_length (req_run_length),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_status     (rsp_status),
      .rsp_slot_free  (rsp_slot_free),
      .rsp_out_id     (rsp_out_id),
      .rsp_out_start  (rsp_out_start),
      .rsp_out_length (rsp_out_length),
      .rsp_fill_count (rsp_fill_count)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Delete one model entry and close the gap behind it
   function automatic void drop_slot(input int unsigned pos);
      for (int unsigned k = pos; k + 1 < model_fill; k++) begin
         model_slots[k] = model_slots[k + 1];
      end
      model_fill--;
   endfunction

   // Apply one command to the model and return the reply it owes
   function automatic reply_type queue_model_step(input logic [OP_W-1:0] op,
                                                   input logic [ID_W-1:0] pid,
                                                   input logic [TIME_W-1:0] st,
                                                   input logic [TIME_W-1:0] dur);
      reply_type         r;
      int                hit;
      logic [TIME_W:0]   prop_end;
      logic [TIME_W:0]   slot_end;
      r = '0;
      hit = -1;
      case (op)
         OP_INSERT: begin
            if (model_fill >= DEPTH) begin
               r.status = ST_FULL;
            end else begin
               model_slots[model_fill] = '{id: pid, start: st, len: dur};
               model_fill++;
            end
         end
         OP_POP: begin
            if (model_fill == 0) begin
               r.status = ST_EMPTY;
            end else begin
               r.id    = model_slots[0].id;
               r.start = model_slots[0].start;
               r.len   = model_slots[0].len;
               drop_slot(0);
            end
         end
         OP_REMOVE: begin
            if (model_fill == 0) begin
               r.status = ST_EMPTY;
            end else begin
               for (int unsigned k = 0; k < model_fill; k++) begin
                  if (hit < 0 && model_slots[k].id == pid) hit = k;
               end
               if (hit >= 0) begin
                  drop_slot(hit);
                  r.status = ST_OK;
               end else begin
                  r.status = ST_NOTFOUND;
               end
            end
         end
         OP_CHECK: begin
            // Inclusive ends on both sides; sums are one bit wider so they never wrap
            r.slot_free = 1'b1;
            prop_end = {1'b0, st} + {1'b0, dur};
            for (int unsigned k = 0; k < model_fill; k++) begin
               slot_end = {1'b0, model_slots[k].start} + {1'b0, model_slots[k].len};
               if ((st >= model_slots[k].start && {1'b0, st} <= slot_end) ||
                   (st <= model_slots[k].start && prop_end >= {1'b0, model_slots[k].start}))
                  r.slot_free = 1'b0;
            end
         end
         default: ;
      endcase
      r.fill = FILL_W'(model_fill);
      return r;
   endfunction

   function automatic logic [TIME_W-1:0] pick_time();
      case ($urandom_range(0, 3))
         0: return TIME_W'($urandom_range(0, 63));
         1: return TIME_W'(16'hFFFF - $urandom_range(0, 3));
         default: return TIME_W'($urandom);
      endcase
   endfunction

   // Favour ids already stored so that removals find a match
   function automatic logic [ID_W-1:0] pick_id();
      if (model_fill > 0 && $urandom_range(0, 1) == 1)
         return model_slots[$urandom_range(0, model_fill - 1)].id;
      if ($urandom_range(0, 1) == 1) return ID_W'($urandom_range(0, 7));
      return ID_W'($urandom);
   endfunction

   // Offer one item, hold it until taken, then record the reply it owes
   task automatic send_item(input logic [OP_W-1:0] op, input logic [ID_W-1:0] pid,
                            input logic [TIME_W-1:0] st, input logic [TIME_W-1:0] dur);
      int gap;
      gap = sender_steady ? 0 : $urandom_range(0, 8);
      @(negedge clock);
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) begin
            {req_operation, req_proc_id, req_start_time, req_run_length} =
               50'({$urandom, $urandom});
            @(negedge clock);
         end
      end
      req_valid      = 1'b1;
      req_operation  = op;
      req_proc_id    = pid;
      req_start_time = st;
      req_run_length = dur;
      @(posedge clock);
      while (req_stall !== 1'b0) @(posedge clock);
      replies_due.push_back(queue_model_step(op, pid, st, dur));
   endtask

   // Drop valid and hold until every owed reply has come back
   task automatic wait_drained();
      @(negedge clock);
      req_valid = 1'b0;
      while (replies_due.size() > 0) @(posedge clock);
   endtask

   task automatic compare_field(input string name, input logic [31:0] want,
                                input logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
         errors++;
      end
   endtask

   // Receiver: hold stall for a drawn number of cycles once a reply is offered
   always @(negedge clock) begin
      if (rsp_valid === 1'b1 && stall_left > 0) begin
         rsp_stall = 1'b1;
         stall_left--;
      end else begin
         rsp_stall = 1'b0;
      end
   end

   // Compare each reply taken with the oldest one owed
   always @(posedge clock) begin
      reply_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (replies_due.size() == 0) begin
            $display("%0t: reply with nothing owed, status %0h fill %0h",
                     $time, rsp_status, rsp_fill_count);
            errors++;
         end else begin
            want = replies_due.pop_front();
            compare_field("status", 32'(want.status), 32'(rsp_status));
            compare_field("slot_free", 32'(want.slot_free), 32'(rsp_slot_free));
            compare_field("out_id", 32'(want.id), 32'(rsp_out_id));
            compare_field("out_start", 32'(want.start), 32'(rsp_out_start));
            compare_field("out_length", 32'(want.len), 32'(rsp_out_length));
            compare_field("fill_count", 32'(want.fill), 32'(rsp_fill_count));
         end
         stall_left = receiver_steady ? 0 : $urandom_range(0, 8);
      end
   end

   // Pop, remove and check on an empty queue
   task automatic test_empty_queue();
      send_item(OP_POP, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      send_item(OP_REMOVE, 16'h0000, 16'h0000, 16'h0000);
      send_item(OP_CHECK, 16'hFFFF, 16'hFFFF, 16'hFFFF);
   endtask

   // Touching interval ends, duplicate ids, missing id and pops in order
   task automatic test_overlap_edges();
      send_item(OP_INSERT, 16'h0000, 16'd100, 16'd50);
      send_item(OP_INSERT, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      send_item(OP_INSERT, 16'h0000, 16'h0000, 16'h0000);
      send_item(OP_CHECK, 16'h1111, 16'd150, 16'd0);
      send_item(OP_CHECK, 16'h2222, 16'd151, 16'd0);
      send_item(OP_CHECK, 16'h3333, 16'd50, 16'd50);
      send_item(OP_CHECK, 16'h4444, 16'd50, 16'd49);
      send_item(OP_CHECK, 16'h5555, 16'hFFFE, 16'd1);
      send_item(OP_REMOVE, 16'h0000, 16'h0000, 16'h0000);
      send_item(OP_REMOVE, 16'h1234, 16'h0000, 16'h0000);
      send_item(OP_POP, 16'h0000, 16'h0000, 16'h0000);
      send_item(OP_POP, 16'h0000, 16'h0000, 16'h0000);
      send_item(OP_POP, 16'h0000, 16'h0000, 16'h0000);
      send_item(OP_CHECK, 16'h0000, 16'h0000, 16'h0000);
   endtask

   // Fill past capacity, pause for the replies, then empty by id
   task automatic test_fill_to_capacity();
      int unsigned k;
      for (int n = 0; n < DEPTH; n++) send_item(OP_INSERT, pick_id(), pick_time(), pick_time());
      send_item(OP_INSERT, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      send_item(OP_CHECK, 16'h0000, 16'h0000, 16'h0000);
      wait_drained();
      while (model_fill > 0) begin
         k = $urandom_range(0, model_fill - 1);
         send_item(OP_REMOVE, model_slots[k].id, pick_time(), pick_time());
      end
      send_item(OP_REMOVE, pick_id(), 16'h0000, 16'h0000);
      send_item(OP_POP, 16'h0000, 16'h0000, 16'h0000);
   endtask

   // Random commands in phases that lean towards filling, draining or neither
   task automatic test_random_traffic(input int count);
      int                bias;
      int                roll;
      int unsigned       k;
      logic [OP_W-1:0]   op;
      logic [TIME_W-1:0] a;
      logic [TIME_W-1:0] l;
      logic [TIME_W-1:0] s;
      logic [TIME_W-1:0] d;
      logic [TIME_W-1:0] x;
      bias = 2;
      for (int n = 0; n < count; n++) begin
         if (n % 100 == 0) begin
            bias = $urandom_range(0, 2);
            sender_steady = ($urandom_range(0, 3) == 0);
            receiver_steady = ($urandom_range(0, 3) == 0);
         end
         roll = $urandom_range(0, 99);
         case (bias)
            0: op = (roll < 55) ? OP_INSERT : (roll < 70) ? OP_POP :
                    (roll < 85) ? OP_REMOVE : OP_CHECK;
            1: op = (roll < 15) ? OP_INSERT : (roll < 50) ? OP_POP :
                    (roll < 85) ? OP_REMOVE : OP_CHECK;
            default: op = (roll < 30) ? OP_INSERT : (roll < 50) ? OP_POP :
                          (roll < 75) ? OP_REMOVE : OP_CHECK;
         endcase
         a = pick_time();
         l = pick_time();
         if (op == OP_CHECK && model_fill > 0 && $urandom_range(0, 1) == 1) begin
            // Aim at the ends of a stored interval
            k = $urandom_range(0, model_fill - 1);
            s = model_slots[k].start;
            d = model_slots[k].len;
            x = TIME_W'($urandom_range(1, 16));
            case ($urandom_range(0, 3))
               0: begin a = s + d;                 l = x;                 end
               1: begin a = s + d + TIME_W'(1);    l = x;                 end
               2: begin a = s - x;                 l = x;                 end
               default: begin a = s - x;           l = x - TIME_W'(1);    end
            endcase
         end
         send_item(op, pick_id(), a, l);
      end
   endtask

   // Stop a hung run
   initial begin
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("tb: FAIL");
      $finish;
   end

   initial begin
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_empty_queue();
      test_overlap_edges();
      test_fill_to_capacity();
      test_random_traffic(1800);
      wait_drained();
      repeat (30) @(posedge clock);
      if (errors == 0 && replies_due.size() == 0) begin
         $display("tb: PASS");
      end else begin
         $display("tb: FAIL");
      end
      $finish;
   end

endmodule

>>> filelist.f
+incdir+hdl
hdl/psq_pkg.sv
hdl/psq_ctrl.sv
hdl/psq_datapath.sv
hdl/process_slot_queue_top.sv
sim/tb.sv
